>>> hdl/rhc_pkg.sv
// Shared types, sizes and constants of the RGB to HSV converter.
package rhc_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int HUE_BITS = 16;
    localparam int NUM_BITS = COMPONENT_BITS + 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int NUM_STAGES = (HUE_BITS > COMPONENT_BITS) ? HUE_BITS : COMPONENT_BITS;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red_in;
        logic [COMPONENT_BITS-1:0] green_in;
        logic [COMPONENT_BITS-1:0] blue_in;
    } rhc_pixel_t;

    typedef struct packed {
        logic [HUE_BITS-1:0]       hue_out;
        logic [COMPONENT_BITS-1:0] saturation_out;
        logic [COMPONENT_BITS-1:0] value_out;
    } rhc_hsv_t;

    typedef struct packed {
        logic [NUM_BITS-1:0]         hue_num;
        logic [NUM_BITS-1:0]         hue_div;
        logic [2*COMPONENT_BITS-1:0] sat_num;
        logic [COMPONENT_BITS-1:0]   sat_div;
        logic [COMPONENT_BITS-1:0]   value;
        logic                        hue_zero;
        logic                        sat_zero;
    } rhc_work_t;

endpackage

>>> hdl/rhc_front.sv
// Front end: accepts pixels and reduces each to the operands of two divisions.
module rhc_front
    import rhc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rhc_pixel_t s_pixel,
    output logic       out_valid,
    input  logic       out_ready,
    output rhc_work_t  out_work
);

    localparam int EXT = NUM_BITS + 1 - COMPONENT_BITS;

    logic                      fr_valid_reg;
    logic                      fr_valid_next;
    rhc_work_t                 fr_work_reg;
    rhc_work_t                 fr_work_next;
    logic [COMPONENT_BITS-1:0] mx;
    logic [COMPONENT_BITS-1:0] mn;
    logic [COMPONENT_BITS-1:0] delta;
    logic [NUM_BITS:0]         ext_r;
    logic [NUM_BITS:0]         ext_g;
    logic [NUM_BITS:0]         ext_b;
    logic [NUM_BITS:0]         ext_d;
    logic [NUM_BITS:0]         d6;
    logic [NUM_BITS:0]         num_raw;
    logic [NUM_BITS:0]         num_fix;
    logic [2*COMPONENT_BITS-1:0] dx2;
    logic                      accept;

    assign s_ready = !fr_valid_reg || out_ready;
    assign accept = s_valid && s_ready;

    always_comb begin
        mx = s_pixel.red_in;
        if (s_pixel.green_in > mx) begin
            mx = s_pixel.green_in;
        end
        if (s_pixel.blue_in > mx) begin
            mx = s_pixel.blue_in;
        end
        mn = s_pixel.red_in;
        if (s_pixel.green_in < mn) begin
            mn = s_pixel.green_in;
        end
        if (s_pixel.blue_in < mn) begin
            mn = s_pixel.blue_in;
        end
        delta = mx - mn;
        ext_r = {{EXT{1'b0}}, s_pixel.red_in};
        ext_g = {{EXT{1'b0}}, s_pixel.green_in};
        ext_b = {{EXT{1'b0}}, s_pixel.blue_in};
        ext_d = {{EXT{1'b0}}, delta};
        d6 = (ext_d << 1) + (ext_d << 2);
        if (mx == s_pixel.red_in) begin
            num_raw = ext_g - ext_b;
        end else if (mx == s_pixel.green_in) begin
            num_raw = (ext_d << 1) + ext_b - ext_r;
        end else begin
            num_raw = (ext_d << 2) + ext_r - ext_g;
        end
        num_fix = num_raw[NUM_BITS] ? (num_raw + d6) : num_raw;
        dx2 = {{COMPONENT_BITS{1'b0}}, delta};
        fr_work_next.hue_num = num_fix[NUM_BITS-1:0];
        fr_work_next.hue_div = d6[NUM_BITS-1:0];
        fr_work_next.sat_num = (dx2 << COMPONENT_BITS) - dx2;
        fr_work_next.sat_div = mx;
        fr_work_next.value = mx;
        fr_work_next.sat_zero = (mx == '0);
        fr_work_next.hue_zero = (mx == '0) || (delta == '0);
    end

    always_comb begin
        fr_valid_next = fr_valid_reg;
        if (s_ready) begin
            fr_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fr_work_reg <= fr_work_next;
        end
    end

    assign out_valid = fr_valid_reg;
    assign out_work = fr_work_reg;

endmodule

>>> hdl/rhc_queue.sv
// Short register queue between the front end and the divider pipeline.
module rhc_queue
    import rhc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  rhc_work_t in_work,
    output logic      out_valid,
    input  logic      out_ready,
    output rhc_work_t out_work
);

    rhc_work_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  push;
    logic                  pop;

    assign in_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_work = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_work;
        end
    end

endmodule

>>> hdl/rhc_back.sv
// Back end: pipelined restoring dividers for hue and saturation, one quotient bit per stage.
module rhc_back
    import rhc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  rhc_work_t in_work,
    output logic      out_valid,
    input  logic      out_ready,
    output rhc_hsv_t  out_hsv
);

    typedef struct packed {
        logic [NUM_BITS-1:0]       hue_rem;
        logic [NUM_BITS-1:0]       hue_div;
        logic [HUE_BITS-1:0]       hue_q;
        logic [COMPONENT_BITS-1:0] sat_rem;
        logic [COMPONENT_BITS-1:0] sat_div;
        logic [COMPONENT_BITS-1:0] sat_lo;
        logic [COMPONENT_BITS-1:0] sat_q;
        logic [COMPONENT_BITS-1:0] value;
        logic                      hue_zero;
        logic                      sat_zero;
    } rhc_stage_t;

    function automatic rhc_stage_t div_step(input rhc_stage_t s, input logic do_hue,
                                            input logic do_sat);
        rhc_stage_t                t;
        logic [NUM_BITS:0]         hr;
        logic [COMPONENT_BITS:0]   sr;
        logic                      hbit;
        logic                      sbit;
        t = s;
        hr = {s.hue_rem, 1'b0};
        hbit = (hr >= {1'b0, s.hue_div});
        if (hbit) begin
            hr = hr - {1'b0, s.hue_div};
        end
        sr = {s.sat_rem, s.sat_lo[COMPONENT_BITS-1]};
        sbit = (sr >= {1'b0, s.sat_div});
        if (sbit) begin
            sr = sr - {1'b0, s.sat_div};
        end
        if (do_hue) begin
            t.hue_rem = hr[NUM_BITS-1:0];
            t.hue_q = {s.hue_q[HUE_BITS-2:0], hbit};
        end
        if (do_sat) begin
            t.sat_rem = sr[COMPONENT_BITS-1:0];
            t.sat_lo = {s.sat_lo[COMPONENT_BITS-2:0], 1'b0};
            t.sat_q = {s.sat_q[COMPONENT_BITS-2:0], sbit};
        end
        return t;
    endfunction

    rhc_stage_t            stage_reg [NUM_STAGES];
    rhc_stage_t            stage_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    rhc_stage_t            prep;
    logic                  advance;

    assign advance = !valid_reg[NUM_STAGES-1] || out_ready;
    assign in_ready = advance;

    always_comb begin
        prep.hue_rem = in_work.hue_num;
        prep.hue_div = in_work.hue_div;
        prep.hue_q = '0;
        prep.sat_rem = in_work.sat_num[2*COMPONENT_BITS-1:COMPONENT_BITS];
        prep.sat_lo = in_work.sat_num[COMPONENT_BITS-1:0];
        prep.sat_div = in_work.sat_div;
        prep.sat_q = '0;
        prep.value = in_work.value;
        prep.hue_zero = in_work.hue_zero;
        prep.sat_zero = in_work.sat_zero;
    end

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            stage_next[k] = div_step((k == 0) ? prep : stage_reg[(k == 0) ? 0 : k-1],
                                     k < HUE_BITS, k < COMPONENT_BITS);
        end
        valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_hsv.hue_out = stage_reg[NUM_STAGES-1].hue_zero ? '0
                                                               : stage_reg[NUM_STAGES-1].hue_q;
    assign out_hsv.saturation_out = stage_reg[NUM_STAGES-1].sat_zero ? '0
                                                                      : stage_reg[NUM_STAGES-1].sat_q;
    assign out_hsv.value_out = stage_reg[NUM_STAGES-1].value;

endmodule

>>> hdl/rgb_to_hsv_converter_core.sv
// Top level of the RGB to HSV converter.
// The s_ channel takes one RGB pixel per beat on s_pixel; the m_ channel delivers one
// HSV pixel per beat on m_hsv, in the order the pixels were taken.
// Both channels are valid/ready; a beat moves when valid and ready are both high.
// Throughput is one pixel per clock cycle while m_ready stays high.
// An input beat travels through the front register, then the queue, then one divider
// pipeline register per quotient bit of the hue divider, which sets the depth.
// The front end keeps accepting pixels while the back end is stalled, until the front
// register and the four-entry queue are full; then s_ready drops.
// When m_valid is high and the receiver holds m_ready low, the divider pipeline holds
// still and m_hsv stays as it is until the beat is taken.
// Reset (aresetn low at a clock edge) empties the front register, the queue and the
// pipeline; no beat is in flight afterward.
module rgb_to_hsv_converter_core
    import rhc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  rhc_pixel_t s_pixel,
    output logic       m_valid,
    input  logic       m_ready,
    output rhc_hsv_t   m_hsv
);

    logic      fr_valid;
    logic      fr_ready;
    rhc_work_t fr_work;
    logic      bk_valid;
    logic      bk_ready;
    rhc_work_t bk_work;

    rhc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_work  (fr_work)
    );

    rhc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_work   (fr_work),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_work  (bk_work)
    );

    rhc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bk_valid),
        .in_ready  (bk_ready),
        .in_work   (bk_work),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_hsv   (m_hsv)
    );

`ifndef SYNTHESIS
    a_stall_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !bk_ready)
        else $error("Queue popped while the output beat was stalled.");

    a_black_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_hsv.value_out == '0)) |->
            ((m_hsv.hue_out == '0) && (m_hsv.saturation_out == '0)))
        else $error("Black pixel produced nonzero hue or saturation.");

    a_full_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (fr_valid && !fr_ready) |-> !s_ready)
        else $error("Input accepted while front register and queue were full.");
`endif

endmodule

>>> tb/tb_rgb_to_hsv_converter_core.sv
// Self-checking testbench for the RGB to HSV converter core.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_converter_core;
    import rhc_pkg::*;

    localparam int CMAX = (1 << COMPONENT_BITS) - 1;
    localparam int RANDOM_PIXELS = 1250;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = NUM_STAGES + 8;
    localparam int NUM_DIRECTED = 24;

    typedef struct packed {
        rhc_pixel_t pix;
        logic       known;
        rhc_hsv_t   hsv;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{8'd0,   8'd0,   8'd0},   1'b1, '{16'd0,     8'd0,   8'd0}},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{16'd0,     8'd0,   8'd255}},
        '{'{8'd255, 8'd0,   8'd0},   1'b1, '{16'd0,     8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd0},   1'b1, '{16'd21845, 8'd255, 8'd255}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{16'd43690, 8'd255, 8'd255}},
        '{'{8'd255, 8'd255, 8'd0},   1'b1, '{16'd10922, 8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{16'd32768, 8'd255, 8'd255}},
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{16'd54613, 8'd255, 8'd255}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{16'd0,     8'd0,   8'd128}},
        '{'{8'd1,   8'd1,   8'd1},   1'b1, '{16'd0,     8'd0,   8'd1}},
        '{'{8'd1,   8'd0,   8'd0},   1'b0, '0},
        '{'{8'd0,   8'd1,   8'd0},   1'b0, '0},
        '{'{8'd0,   8'd0,   8'd1},   1'b0, '0},
        '{'{8'd255, 8'd254, 8'd255}, 1'b0, '0},
        '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
        '{'{8'd255, 8'd0,   8'd1},   1'b0, '0},
        '{'{8'd170, 8'd85,  8'd0},   1'b0, '0},
        '{'{8'd0,   8'd85,  8'd170}, 1'b0, '0},
        '{'{8'd100, 8'd200, 8'd150}, 1'b0, '0},
        '{'{8'd200, 8'd100, 8'd150}, 1'b0, '0},
        '{'{8'd255, 8'd1,   8'd0},   1'b0, '0},
        '{'{8'd1,   8'd255, 8'd254}, 1'b0, '0},
        '{'{8'd128, 8'd0,   8'd255}, 1'b0, '0},
        '{'{8'd254, 8'd254, 8'd255}, 1'b0, '0}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    rhc_pixel_t s_pixel;
    logic       m_valid;
    logic       m_ready;
    rhc_hsv_t   m_hsv;

    rhc_hsv_t expected_hsv [$];
    int       pixels_sent = 0;
    int       hsv_checked = 0;
    int       mismatch_count = 0;
    int       idle_cycles = 0;
    logic     tx_quiet = 1'b0;
    logic     rx_quiet = 1'b0;

    rgb_to_hsv_converter_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pixel (s_pixel),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_hsv   (m_hsv)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic rhc_hsv_t predict_hsv(input rhc_pixel_t pix);
        rhc_hsv_t hsv;
        int       r;
        int       g;
        int       b;
        int       top;
        int       bottom;
        int       spread;
        longint   num;
        r = int'(pix.red_in);
        g = int'(pix.green_in);
        b = int'(pix.blue_in);
        top = r;
        if (g > top) top = g;
        if (b > top) top = b;
        bottom = r;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        spread = top - bottom;
        hsv.value_out = COMPONENT_BITS'(top);
        hsv.saturation_out = '0;
        hsv.hue_out = '0;
        if (top != 0) begin
            hsv.saturation_out = COMPONENT_BITS'((spread * CMAX) / top);
            if (spread != 0) begin
                if (top == r) begin
                    num = g - b;
                end else if (top == g) begin
                    num = 2 * spread + (b - r);
                end else begin
                    num = 4 * spread + (r - g);
                end
                if (num < 0) num = num + 6 * spread;
                hsv.hue_out = HUE_BITS'((num << HUE_BITS) / (6 * spread));
            end
        end
        return hsv;
    endfunction

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic rhc_pixel_t random_pixel();
        rhc_pixel_t pix;
        int         kind;
        int         base;
        int         other;
        int         pick;
        kind = $urandom_range(0, 99);
        base = $urandom_range(0, 255);
        other = $urandom_range(0, 255);
        pix.red_in = COMPONENT_BITS'($urandom_range(0, 255));
        pix.green_in = COMPONENT_BITS'($urandom_range(0, 255));
        pix.blue_in = COMPONENT_BITS'($urandom_range(0, 255));
        if (kind >= 50 && kind < 65) begin
            // Two components share a value so the maximum may be tied.
            pick = $urandom_range(0, 2);
            pix.red_in = COMPONENT_BITS'(pick == 2 ? other : base);
            pix.green_in = COMPONENT_BITS'(pick == 1 ? other : base);
            pix.blue_in = COMPONENT_BITS'(pick == 0 ? other : base);
        end else if (kind >= 65 && kind < 70) begin
            pix.red_in = COMPONENT_BITS'(base);
            pix.green_in = COMPONENT_BITS'(base);
            pix.blue_in = COMPONENT_BITS'(base);
        end else if (kind >= 70 && kind < 85) begin
            pick = $urandom_range(0, 3);
            pix.red_in = COMPONENT_BITS'(pick < 2 ? pick : CMAX - 3 + pick);
            pick = $urandom_range(0, 3);
            pix.green_in = COMPONENT_BITS'(pick < 2 ? pick : CMAX - 3 + pick);
            pick = $urandom_range(0, 3);
            pix.blue_in = COMPONENT_BITS'(pick < 2 ? pick : CMAX - 3 + pick);
        end else if (kind >= 85) begin
            base = $urandom_range(0, CMAX - 3);
            pix.red_in = COMPONENT_BITS'(base + $urandom_range(0, 3));
            pix.green_in = COMPONENT_BITS'(base + $urandom_range(0, 3));
            pix.blue_in = COMPONENT_BITS'(base + $urandom_range(0, 3));
        end
        return pix;
    endfunction

    task automatic send_pixel(input rhc_pixel_t pix, input logic known, input rhc_hsv_t hsv);
        s_valid <= 1'b1;
        s_pixel <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_hsv.push_back(known ? hsv : predict_hsv(pix));
        pixels_sent++;
        if (!tx_quiet && $urandom_range(0, 99) < 45) begin
            s_valid <= 1'b0;
            repeat (idle_length()) @(posedge aclk);
        end
    endtask

    initial begin
        s_valid <= 1'b0;
        s_pixel <= '0;
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].hsv);
        end
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 100 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            send_pixel(random_pixel(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d RGB beats (%0d directed, %0d random).",
                 pixels_sent, NUM_DIRECTED, RANDOM_PIXELS);
        $display("Checked %0d HSV beats with %0d mismatches.", hsv_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 99) < 2) rx_quiet = ~rx_quiet;
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (!rx_quiet) begin
                m_ready <= 1'b0;
                repeat (idle_length()) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        rhc_hsv_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hsv.size() == 0) begin
                $display("%0t: unexpected HSV beat hue %0d sat %0d value %0d", $time,
                         m_hsv.hue_out, m_hsv.saturation_out, m_hsv.value_out);
                mismatch_count++;
            end else begin
                want = expected_hsv.pop_front();
                hsv_checked++;
                if (m_hsv.hue_out !== want.hue_out) begin
                    $display("%0t: hue mismatch, expected %0d actual %0d", $time,
                             want.hue_out, m_hsv.hue_out);
                    mismatch_count++;
                end
                if (m_hsv.saturation_out !== want.saturation_out) begin
                    $display("%0t: saturation mismatch, expected %0d actual %0d", $time,
                             want.saturation_out, m_hsv.saturation_out);
                    mismatch_count++;
                end
                if (m_hsv.value_out !== want.value_out) begin
                    $display("%0t: value mismatch, expected %0d actual %0d", $time,
                             want.value_out, m_hsv.value_out);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles.", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

>>> rgb_to_hsv_converter_core.f
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_queue.sv
hdl/rhc_back.sv
hdl/rgb_to_hsv_converter_core.sv
tb/tb_rgb_to_hsv_converter_core.sv
